// File: rtl/core/spd_pkg.sv
// ----------------------------------------------------------------------------
// Sync packet deframer package
// Shared types and constants for the sync packet deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package spd_pkg;

    localparam logic [7:0]  SYNC_BYTE          = 8'hAA;
    localparam logic [15:0] MAX_LEN_RESET      = 16'd256;
    localparam logic [31:0] HUNT_LIMIT_RESET   = 32'd16800;

    localparam int unsigned CFG_INDEX_WIDTH    = 8;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_MAX_PAYLOAD_LENGTH = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] CFG_HUNT_LIMIT         = 8'd1;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_OPCODE,
        PH_SEQ,
        PH_LEN_HI,
        PH_LEN_LO,
        PH_PAYLOAD,
        PH_CHECK
    } phase_t;

    typedef enum logic {
        KIND_PAYLOAD = 1'b0,
        KIND_STATUS  = 1'b1
    } kind_t;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_TIMEOUT   = 2'd1,
        STATUS_TOO_LONG  = 2'd2,
        STATUS_BAD_CHECK = 2'd3
    } status_t;

    typedef struct packed {
        kind_t       kind;
        logic [7:0]  payload_byte;
        logic [15:0] byte_index;
        logic [7:0]  opcode;
        logic [7:0]  sequence_num;
        logic [15:0] length;
        status_t     status;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/core/spd_parser.sv
// ----------------------------------------------------------------------------
// Sync packet deframer parser
// Frame state machine: sync hunt, header capture, payload and checksum check.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_parser
(
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            step,
    input  wire logic [7:0]      rx_byte,
    input  wire logic [15:0]     max_len,
    input  wire logic [31:0]     hunt_limit,
    output spd_pkg::result_t     res,
    output logic                 res_valid
);

    spd_pkg::phase_t phase_reg, phase_next;
    logic [31:0] hunt_count_reg, hunt_count_next;
    logic [7:0]  opcode_reg, opcode_next;
    logic [7:0]  sequence_reg, sequence_next;
    logic [15:0] length_reg, length_next;
    logic [15:0] payload_count_reg, payload_count_next;
    logic [7:0]  xor_reg, xor_next;

    logic [31:0] limit;
    logic [31:0] hunt_count_inc;
    logic [15:0] payload_count_inc;
    logic [15:0] full_length;
    logic        is_sync;
    logic        timeout;
    logic        too_long;

    assign limit             = (hunt_limit == 32'd0) ? 32'd1 : hunt_limit;
    assign hunt_count_inc    = hunt_count_reg + 32'd1;
    assign payload_count_inc = payload_count_reg + 16'd1;
    assign full_length       = {length_reg[15:8], rx_byte};
    assign is_sync           = (rx_byte == spd_pkg::SYNC_BYTE);
    assign timeout           = !is_sync && (hunt_count_inc >= limit);
    assign too_long          = (full_length > max_len);

    // Next state.
    always_comb
    begin
        phase_next         = phase_reg;
        hunt_count_next    = hunt_count_reg;
        opcode_next        = opcode_reg;
        sequence_next      = sequence_reg;
        length_next        = length_reg;
        payload_count_next = payload_count_reg;
        xor_next           = xor_reg;
        unique case (phase_reg)
            spd_pkg::PH_HUNT:
            begin
                if (is_sync)
                begin
                    hunt_count_next = 32'd0;
                    xor_next        = 8'd0;
                    phase_next      = spd_pkg::PH_OPCODE;
                end
                else if (timeout)
                begin
                    hunt_count_next = 32'd0;
                end
                else
                begin
                    hunt_count_next = hunt_count_inc;
                end
            end
            spd_pkg::PH_OPCODE:
            begin
                opcode_next = rx_byte;
                xor_next    = rx_byte;
                phase_next  = spd_pkg::PH_SEQ;
            end
            spd_pkg::PH_SEQ:
            begin
                sequence_next = rx_byte;
                xor_next      = xor_reg ^ rx_byte;
                phase_next    = spd_pkg::PH_LEN_HI;
            end
            spd_pkg::PH_LEN_HI:
            begin
                length_next = {rx_byte, 8'h00};
                xor_next    = xor_reg ^ rx_byte;
                phase_next  = spd_pkg::PH_LEN_LO;
            end
            spd_pkg::PH_LEN_LO:
            begin
                length_next        = full_length;
                xor_next           = xor_reg ^ rx_byte;
                payload_count_next = 16'd0;
                if (too_long)
                begin
                    phase_next      = spd_pkg::PH_HUNT;
                    hunt_count_next = 32'd0;
                end
                else if (full_length == 16'd0)
                begin
                    phase_next = spd_pkg::PH_CHECK;
                end
                else
                begin
                    phase_next = spd_pkg::PH_PAYLOAD;
                end
            end
            spd_pkg::PH_PAYLOAD:
            begin
                xor_next           = xor_reg ^ rx_byte;
                payload_count_next = payload_count_inc;
                if (payload_count_inc >= length_reg)
                begin
                    phase_next = spd_pkg::PH_CHECK;
                end
            end
            spd_pkg::PH_CHECK:
            begin
                phase_next      = spd_pkg::PH_HUNT;
                hunt_count_next = 32'd0;
            end
            default:
            begin
                phase_next      = spd_pkg::PH_HUNT;
                hunt_count_next = 32'd0;
            end
        endcase
    end

    // Result for the byte now in the input stage.
    always_comb
    begin
        res_valid        = 1'b0;
        res.kind         = spd_pkg::KIND_STATUS;
        res.payload_byte = 8'd0;
        res.byte_index   = 16'd0;
        res.opcode       = opcode_reg;
        res.sequence_num = sequence_reg;
        res.length       = length_reg;
        res.status       = spd_pkg::STATUS_OK;
        unique case (phase_reg)
            spd_pkg::PH_HUNT:
            begin
                res_valid        = timeout;
                res.opcode       = 8'd0;
                res.sequence_num = 8'd0;
                res.length       = 16'd0;
                res.status       = spd_pkg::STATUS_TIMEOUT;
            end
            spd_pkg::PH_LEN_LO:
            begin
                res_valid  = too_long;
                res.length = full_length;
                res.status = spd_pkg::STATUS_TOO_LONG;
            end
            spd_pkg::PH_PAYLOAD:
            begin
                res_valid        = 1'b1;
                res.kind         = spd_pkg::KIND_PAYLOAD;
                res.payload_byte = rx_byte;
                res.byte_index   = payload_count_reg;
            end
            spd_pkg::PH_CHECK:
            begin
                res_valid  = 1'b1;
                res.status = (xor_reg == rx_byte) ? spd_pkg::STATUS_OK
                                                  : spd_pkg::STATUS_BAD_CHECK;
            end
            default:
            begin
                res_valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= spd_pkg::PH_HUNT;
            hunt_count_reg    <= 32'd0;
            opcode_reg        <= 8'd0;
            sequence_reg      <= 8'd0;
            length_reg        <= 16'd0;
            payload_count_reg <= 16'd0;
            xor_reg           <= 8'd0;
        end
        else if (step)
        begin
            phase_reg         <= phase_next;
            hunt_count_reg    <= hunt_count_next;
            opcode_reg        <= opcode_next;
            sequence_reg      <= sequence_next;
            length_reg        <= length_next;
            payload_count_reg <= payload_count_next;
            xor_reg           <= xor_next;
        end
    end

    // A frame only sits in the payload phase while bytes are still owed.
    a_payload_owed: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == spd_pkg::PH_PAYLOAD |-> payload_count_reg < length_reg)
        else $error("payload phase with no payload bytes left");

    a_payload_phase: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.kind == spd_pkg::KIND_PAYLOAD |-> phase_reg == spd_pkg::PH_PAYLOAD)
        else $error("payload result outside payload phase");

    a_sync_start: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == spd_pkg::PH_HUNT && rx_byte == spd_pkg::SYNC_BYTE
        |=> phase_reg == spd_pkg::PH_OPCODE && hunt_count_reg == 32'd0)
        else $error("sync byte did not start a frame");

endmodule

`default_nettype wire

// File: rtl/core/spd_out_reg.sv
// ----------------------------------------------------------------------------
// Sync packet deframer output register
// Holds one result item until the downstream side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module spd_out_reg
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load,
    input  wire spd_pkg::result_t  res_in,
    input  wire logic              out_ready,
    output logic                   out_valid,
    output spd_pkg::result_t       res_out,
    output logic                   free
);

    logic             valid_reg, valid_next;
    spd_pkg::result_t res_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res_in;
        end
    end

    assign out_valid = valid_reg;
    assign res_out   = res_reg;

endmodule

`default_nettype wire

// File: rtl/core/sync_packet_deframer.sv
// ----------------------------------------------------------------------------
// Sync packet deframer
// Byte-serial frame parser with sync hunt, length check and XOR checksum.
// ----------------------------------------------------------------------------
//  Channel  Handshake               Payload
//  in       in_valid / in_ready     rx_byte
//  out      out_valid / out_ready   result_kind, payload_byte, byte_index,
//                                   frame_opcode, frame_sequence,
//                                   frame_length, frame_status
//  cfg      cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One byte is accepted per cycle unless a staged result must wait for the output.
// Throughput is set by the single input stage feeding the parser state machine.
// Reset returns the parser to sync hunt and loads the register defaults.
// A stalled output holds up only bytes that produce a result; others still pass.
// Configuration writes are always ready and take effect on the next byte.
// ----------------------------------------------------------------------------
`default_nettype none

module sync_packet_deframer
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [7:0]  rx_byte,

    output logic             out_valid,
    input  wire logic        out_ready,
    output logic             result_kind,
    output logic [7:0]       payload_byte,
    output logic [15:0]      byte_index,
    output logic [7:0]       frame_opcode,
    output logic [7:0]       frame_sequence,
    output logic [15:0]      frame_length,
    output logic [1:0]       frame_status,

    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [spd_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
    input  wire logic [31:0] cfg_data
);

    logic [15:0] max_len_reg;
    logic [31:0] hunt_limit_reg;

    logic        stage_valid_reg;
    logic [7:0]  stage_byte_reg;

    spd_pkg::result_t res;
    spd_pkg::result_t res_out;
    logic             res_valid;
    logic             out_free;
    logic             step;
    logic             in_accept;

    assign cfg_ready = 1'b1;
    assign step      = stage_valid_reg && (!res_valid || out_free);
    assign in_ready  = !stage_valid_reg || step;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_len_reg    <= spd_pkg::MAX_LEN_RESET;
            hunt_limit_reg <= spd_pkg::HUNT_LIMIT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                spd_pkg::CFG_MAX_PAYLOAD_LENGTH: max_len_reg    <= cfg_data[15:0];
                spd_pkg::CFG_HUNT_LIMIT:         hunt_limit_reg <= cfg_data;
                default:                         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            stage_valid_reg <= 1'b1;
        end
        else if (step)
        begin
            stage_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            stage_byte_reg <= rx_byte;
        end
    end

    spd_parser u_parser
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (step),
        .rx_byte    (stage_byte_reg),
        .max_len    (max_len_reg),
        .hunt_limit (hunt_limit_reg),
        .res        (res),
        .res_valid  (res_valid)
    );

    spd_out_reg u_out_reg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step && res_valid),
        .res_in    (res),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .res_out   (res_out),
        .free      (out_free)
    );

    assign result_kind    = res_out.kind;
    assign payload_byte   = res_out.payload_byte;
    assign byte_index     = res_out.byte_index;
    assign frame_opcode   = res_out.opcode;
    assign frame_sequence = res_out.sequence_num;
    assign frame_length   = res_out.length;
    assign frame_status   = res_out.status;

    // An item with a result must wait while the output register is full and not taken.
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready && res_valid |-> !step)
        else $error("result would overwrite a pending output item");

    a_stage_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> stage_valid_reg)
        else $error("accepted item missing from input stage");

    a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !stage_valid_reg |-> in_ready)
        else $error("empty input stage refused an item");

endmodule

`default_nettype wire
